// ===== rtl/refcounted_block_table_core_macros.svh =====
// Assertion macros shared by the block's checker.
`ifndef REFCOUNTED_BLOCK_TABLE_CORE_MACROS_SVH
`define REFCOUNTED_BLOCK_TABLE_CORE_MACROS_SVH

// Clocked check, masked while reset is high.
`define RBT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked check that also holds across reset.
`define RBT_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/rbt_pkg.sv =====
// Shared types, codes and defaults for the refcounted block table.
package rbt_pkg;

   localparam int TABLE_DEPTH_DEF = 16;
   localparam int OFFSET_BITS_DEF = 32;
   localparam int REF_BITS_DEF    = 16;

   localparam logic [1:0] MODE_ADD    = 2'd0;
   localparam logic [1:0] MODE_REMOVE = 2'd1;
   localparam logic [1:0] MODE_LOOKUP = 2'd2;

   typedef enum logic [2:0] {
      STAT_OK     = 3'd0,
      STAT_ZERO   = 3'd1,
      STAT_LISTED = 3'd2,
      STAT_DUP    = 3'd3,
      STAT_FULL   = 3'd4,
      STAT_EMPTY  = 3'd5,
      STAT_MISS   = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_COMMIT
   } state_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] block_offset;
      logic        already_listed;
      logic [15:0] initial_refs;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] ref_count;
      logic [3:0]  slot_index;
      logic        hit;
      logic        released;
   } rsp_type;

   // handoff from the engine to the output register
   typedef struct packed {
      logic    valid;
      rsp_type data;
   } result_type;

endpackage

// ===== rtl/rbt_mem.sv =====
// Single-port-write, registered-read memory holding slot offset and count.
module rbt_mem #(
   parameter int  DEPTH = rbt_pkg::TABLE_DEPTH_DEF,
   parameter int  WIDTH = rbt_pkg::OFFSET_BITS_DEF + rbt_pkg::REF_BITS_DEF,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/rbt_engine.sv =====
// Scan sequencer, valid bits, fill count and commit decode for the table.
module rbt_engine #(
   parameter int  TABLE_DEPTH = rbt_pkg::TABLE_DEPTH_DEF,
   parameter int  OFFSET_BITS = rbt_pkg::OFFSET_BITS_DEF,
   parameter int  REF_BITS    = rbt_pkg::REF_BITS_DEF,
   localparam int IDX_BITS    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
   localparam int ENT_BITS    = OFFSET_BITS + REF_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  rbt_pkg::req_type     req_data,
   output rbt_pkg::result_type  result,
   input  logic                 result_take,
   output logic                 mem_rd_en,
   output logic [IDX_BITS-1:0]  mem_rd_addr,
   input  logic [ENT_BITS-1:0]  mem_rd_data,
   output logic                 mem_wr_en,
   output logic [IDX_BITS-1:0]  mem_wr_addr,
   output logic [ENT_BITS-1:0]  mem_wr_data
);
   import rbt_pkg::*;

   localparam int CNT_BITS = $clog2(TABLE_DEPTH + 1);
   localparam int INIT_W   = (REF_BITS > 16) ? REF_BITS : 16;
   localparam logic [REF_BITS-1:0] REF_MAX = '1;

   function automatic logic [REF_BITS-1:0] sat_inc(input logic [REF_BITS-1:0] v);
      return (v == REF_MAX) ? v : v + REF_BITS'(1);
   endfunction

   state_type state_ff, state_in;

   req_type              req_ff, req_in;
   logic [OFFSET_BITS-1:0] ofs_ff, ofs_in;
   logic [CNT_BITS-1:0]  issue_ff, issue_in;
   logic                 chk_valid_ff, chk_valid_in;
   logic [IDX_BITS-1:0]  chk_idx_ff, chk_idx_in;
   logic                 hit_found_ff, hit_found_in;
   logic [IDX_BITS-1:0]  hit_idx_ff, hit_idx_in;
   logic [REF_BITS-1:0]  hit_refs_ff, hit_refs_in;
   logic                 free_found_ff, free_found_in;
   logic [IDX_BITS-1:0]  free_idx_ff, free_idx_in;
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [CNT_BITS-1:0]  used_ff, used_in;

   logic [OFFSET_BITS-1:0] ent_ofs;
   logic [REF_BITS-1:0]    ent_refs;
   logic [INIT_W-1:0]      init_w;
   logic [REF_BITS-1:0]    init_refs;
   logic                   commit;
   logic                   set_valid, clr_valid, inc_used, dec_used, wr_c;
   logic [IDX_BITS-1:0]    slot;
   logic [REF_BITS-1:0]    new_refs;
   rsp_type                res;

   assign ent_ofs  = mem_rd_data[ENT_BITS-1:REF_BITS];
   assign ent_refs = mem_rd_data[REF_BITS-1:0];

   // requested count clamped to the count range, then bumped
   assign init_w    = INIT_W'(req_ff.initial_refs);
   assign init_refs = sat_inc((init_w > INIT_W'(REF_MAX)) ? REF_MAX
                                                          : REF_BITS'(init_w));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chk_valid_ff <= 1'b0;
         valid_ff     <= '0;
         used_ff      <= '0;
      end else begin
         chk_valid_ff <= chk_valid_in;
         valid_ff     <= valid_in;
         used_ff      <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      ofs_ff        <= ofs_in;
      issue_ff      <= issue_in;
      chk_idx_ff    <= chk_idx_in;
      hit_found_ff  <= hit_found_in;
      hit_idx_ff    <= hit_idx_in;
      hit_refs_ff   <= hit_refs_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
   end

   // commit decode: pick status and the table update from the scan outcome
   always_comb begin
      res        = '0;
      res.status = STAT_OK;
      set_valid  = 1'b0;
      clr_valid  = 1'b0;
      inc_used   = 1'b0;
      dec_used   = 1'b0;
      wr_c       = 1'b0;
      slot       = hit_idx_ff;
      new_refs   = sat_inc(hit_refs_ff);
      case (req_ff.mode)
         MODE_ADD: begin
            if (ofs_ff == '0) begin
               res.status = STAT_ZERO;
            end else if (req_ff.already_listed) begin
               res.status = STAT_LISTED;
            end else if (hit_found_ff) begin
               res.status = STAT_DUP;
               res.hit    = 1'b1;
               wr_c       = 1'b1;
            end else if (used_ff >= CNT_BITS'(TABLE_DEPTH) || !free_found_ff) begin
               res.status = STAT_FULL;
            end else begin
               slot      = free_idx_ff;
               new_refs  = init_refs;
               wr_c      = 1'b1;
               set_valid = 1'b1;
               inc_used  = 1'b1;
            end
         end
         MODE_REMOVE: begin
            if (ofs_ff == '0) begin
               res.status = STAT_ZERO;
            end else if (used_ff == '0) begin
               res.status = STAT_EMPTY;
            end else if (!hit_found_ff) begin
               res.status = STAT_MISS;
            end else if (hit_refs_ff <= REF_BITS'(1)) begin
               res.hit      = 1'b1;
               res.released = 1'b1;
               clr_valid    = 1'b1;
               dec_used     = 1'b1;
               new_refs     = '0;
            end else begin
               res.hit  = 1'b1;
               new_refs = hit_refs_ff - REF_BITS'(1);
               wr_c     = 1'b1;
            end
         end
         MODE_LOOKUP: begin
            if (!hit_found_ff) begin
               res.status = STAT_MISS;
            end else begin
               res.hit = 1'b1;
               wr_c    = 1'b1;
            end
         end
         default: begin
            res.status = STAT_OK;
         end
      endcase
      // slot and count show only when an entry was touched
      if (wr_c || clr_valid) begin
         res.slot_index = 4'(slot);
         res.ref_count  = 16'(new_refs);
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      ofs_in        = ofs_ff;
      issue_in      = issue_ff;
      chk_valid_in  = 1'b0;
      chk_idx_in    = issue_ff[IDX_BITS-1:0];
      hit_found_in  = hit_found_ff;
      hit_idx_in    = hit_idx_ff;
      hit_refs_in   = hit_refs_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      valid_in      = valid_ff;
      used_in       = used_ff;
      req_stall     = (state_ff != S_IDLE);
      mem_rd_en     = 1'b0;
      mem_rd_addr   = issue_ff[IDX_BITS-1:0];
      result.valid  = (state_ff == S_COMMIT);
      result.data   = res;
      commit        = (state_ff == S_COMMIT) && result_take;
      mem_wr_en     = commit && wr_c;
      mem_wr_addr   = slot;
      mem_wr_data   = {ofs_ff, new_refs};

      // compare stage, in the cycle after the read
      if (chk_valid_ff) begin
         if (valid_ff[chk_idx_ff] && ent_ofs == ofs_ff && !hit_found_ff) begin
            hit_found_in = 1'b1;
            hit_idx_in   = chk_idx_ff;
            hit_refs_in  = ent_refs;
         end
         if (!valid_ff[chk_idx_ff] && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = chk_idx_ff;
         end
      end

      if (commit) begin
         if (set_valid) begin
            valid_in[slot] = 1'b1;
         end
         if (clr_valid) begin
            valid_in[slot] = 1'b0;
         end
         if (inc_used) begin
            used_in = used_ff + CNT_BITS'(1);
         end
         if (dec_used) begin
            used_in = used_ff - CNT_BITS'(1);
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in        = req_data;
               ofs_in        = OFFSET_BITS'(req_data.block_offset);
               issue_in      = '0;
               hit_found_in  = 1'b0;
               free_found_in = 1'b0;
               state_in      = S_SCAN;
            end
         end
         S_SCAN: begin
            mem_rd_en    = 1'b1;
            chk_valid_in = 1'b1;
            issue_in     = issue_ff + CNT_BITS'(1);
            if (issue_ff == CNT_BITS'(TABLE_DEPTH - 1)) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (result_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/refcounted_block_table_core.sv =====
// Requests are taken one at a time, only while the engine is idle; the single memory read
// port walks every slot once per request, then the drain state finishes the last compare
// and the commit state writes the result back.
// A finished response waits in the output register, so the next request is taken
// while it is stalled. Reset (synchronous, active high) clears valid bits, fill count,
// sequencer and output valid; offset/count memory contents are not cleared.
module refcounted_block_table_core #(
   parameter int TABLE_DEPTH = rbt_pkg::TABLE_DEPTH_DEF,
   parameter int OFFSET_BITS = rbt_pkg::OFFSET_BITS_DEF,
   parameter int REF_BITS    = rbt_pkg::REF_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rbt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rbt_pkg::rsp_type rsp_data
);
   import rbt_pkg::*;

   localparam int IDX_BITS = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int ENT_BITS = OFFSET_BITS + REF_BITS;

   // memory side: one read per scan cycle, at most one write at commit
   logic                mem_rd_en;
   logic [IDX_BITS-1:0] mem_rd_addr;
   logic [ENT_BITS-1:0] mem_rd_data;
   logic                mem_wr_en;
   logic [IDX_BITS-1:0] mem_wr_addr;
   logic [ENT_BITS-1:0] mem_wr_data;

   result_type result;
   logic       result_take;

   // output register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   // The write lands in the commit cycle; the next request's first read comes only
   // after the engine has passed through idle into scan, so no forwarding path is needed.
   rbt_mem #(
      .DEPTH (TABLE_DEPTH),
      .WIDTH (ENT_BITS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   rbt_engine #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .OFFSET_BITS (OFFSET_BITS),
      .REF_BITS    (REF_BITS)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .result      (result),
      .result_take (result_take),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data)
   );

   // the output register can take a new beat when empty or draining now
   assign result_take = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (result.valid && result_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result.data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/rbt_checker.sv =====
// Port-level checker for the refcounted block table, bound to the top level.
`include "refcounted_block_table_core_macros.svh"

module rbt_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input rbt_pkg::rsp_type rsp_data
);
   import rbt_pkg::*;

   `RBT_ASSERT_ALWAYS(a_rsp_idle_after_reset, reset |=> !rsp_valid, "rsp_valid high right after reset")
   `RBT_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "stalled response beat changed")
   `RBT_ASSERT(a_busy_after_req, req_valid && !req_stall |=> req_stall && !$rose(rsp_valid), "request beat not followed by a busy scan")
   `RBT_ASSERT(a_release_fields, rsp_valid && rsp_data.released |-> rsp_data.hit && rsp_data.ref_count == 16'd0 && rsp_data.status == STAT_OK, "release response inconsistent")

endmodule

bind refcounted_block_table_core rbt_checker u_rbt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== sim/refcounted_block_table_core_tb.sv =====
// Self-checking testbench for refcounted_block_table_core: corner requests, then random traffic.
module refcounted_block_table_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rbt_pkg::*;

   localparam int         SLOTS        = TABLE_DEPTH_DEF;
   localparam logic [1:0] MODE_UNUSED  = 2'd3;   // spare code, block must ignore it
   localparam int         RANDOM_BEATS = 1900;
   localparam int         POOL_SIZE    = 24;     // more offsets than slots, so the table fills
   localparam int         HEAVY_SLOTS  = 3;      // pool entries allowed to carry huge counts
   localparam int         REPORT_LIMIT = 10;

   // ------------------------------------------------------------------
   // Mirror of the slot table. It tracks valid bits, offsets and counts,
   // works out each response as a request beat is accepted, and holds the
   // responses still owed by the block in arrival order.
   // ------------------------------------------------------------------
   class refcount_mirror;
      bit          held [SLOTS];
      logic [31:0] held_offset [SLOTS];
      logic [15:0] held_refs [SLOTS];
      int          held_count;
      rsp_type     awaited_rsps [$];
      int          errors;
      int          checked;
      int          freed_seen;
      int          status_seen [8];

      function int find_held(logic [31:0] ofs);
         for (int i = 0; i < SLOTS; i++)
            if (held[i] && held_offset[i] == ofs) return i;
         return -1;
      endfunction

      // counts stick at all ones
      function logic [15:0] bump_refs(logic [15:0] v);
         return (v == 16'hFFFF) ? v : v + 16'd1;
      endfunction

      function string show(rsp_type r);
         return $sformatf("status=%0d refs=%0d slot=%0d hit=%0b rel=%0b",
                          r.status, r.ref_count, r.slot_index, r.hit, r.released);
      endfunction

      function void flag_error(string msg);
         errors++;
         if (errors <= REPORT_LIMIT) $display("[%0t] ERROR: %s", $time, msg);
      endfunction

      function void note_request(req_type r);
         rsp_type want;
         int      s;
         want = '0;
         s    = -1;
         case (r.mode)
            MODE_ADD: begin
               if (r.block_offset == '0) want.status = STAT_ZERO;
               else if (r.already_listed) want.status = STAT_LISTED;
               else begin
                  s = find_held(r.block_offset);
                  if (s >= 0) begin
                     held_refs[s] = bump_refs(held_refs[s]);
                     want.status  = STAT_DUP;
                     want.hit     = 1'b1;
                  end else if (held_count >= SLOTS) begin
                     want.status = STAT_FULL;
                  end else begin
                     // lowest free slot wins
                     for (int i = SLOTS - 1; i >= 0; i--)
                        if (!held[i]) s = i;
                     held[s]        = 1'b1;
                     held_offset[s] = r.block_offset;
                     held_refs[s]   = bump_refs(r.initial_refs);
                     held_count++;
                  end
                  if (s >= 0) begin
                     want.ref_count  = held_refs[s];
                     want.slot_index = s[3:0];
                  end
               end
            end
            MODE_REMOVE: begin
               if (r.block_offset == '0) want.status = STAT_ZERO;
               else if (held_count == 0) want.status = STAT_EMPTY;
               else begin
                  s = find_held(r.block_offset);
                  if (s < 0) want.status = STAT_MISS;
                  else begin
                     want.hit        = 1'b1;
                     want.slot_index = s[3:0];
                     if (held_refs[s] <= 16'd1) begin
                        held[s]       = 1'b0;
                        held_refs[s]  = '0;
                        held_count--;
                        want.released = 1'b1;
                     end else begin
                        held_refs[s]   = held_refs[s] - 16'd1;
                        want.ref_count = held_refs[s];
                     end
                  end
               end
            end
            MODE_LOOKUP: begin
               s = find_held(r.block_offset);
               if (s < 0) want.status = STAT_MISS;
               else begin
                  held_refs[s]    = bump_refs(held_refs[s]);
                  want.ref_count  = held_refs[s];
                  want.slot_index = s[3:0];
                  want.hit        = 1'b1;
               end
            end
            default: ;  // spare mode: no effect, all-zero response
         endcase
         status_seen[want.status]++;
         if (want.released) freed_seen++;
         awaited_rsps.push_back(want);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         checked++;
         if (awaited_rsps.size() == 0) begin
            flag_error($sformatf("response %s with nothing outstanding", show(got)));
            return;
         end
         want = awaited_rsps.pop_front();
         if (got.status !== want.status || got.ref_count !== want.ref_count ||
             got.slot_index !== want.slot_index || got.hit !== want.hit ||
             got.released !== want.released)
            flag_error($sformatf("response %0d: expected %s, got %s",
                                 checked, show(want), show(got)));
      endfunction
   endclass

   // ------------------------------------------------------------------
   // Clock, reset and DUT
   // ------------------------------------------------------------------
   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   bit          steady_run = 1'b0;   // no idling on either side while set
   int          stall_left = 0;
   int          beats_sent = 0;
   logic [31:0] offset_pool [POOL_SIZE];
   req_type     corner_reqs [$];

   refcount_mirror board = new();

   always #6 clock = ~clock;

   refcounted_block_table_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // ------------------------------------------------------------------
   // Request side. Everything is driven with NBAs right after a rising
   // edge; req_stall is read in the active region of the edge, so it is
   // the value the DUT presented for that edge.
   // ------------------------------------------------------------------
   function automatic req_type make_req(logic [1:0] m, logic [31:0] ofs, logic listed,
                                        logic [15:0] refs);
      req_type r;
      r.mode           = m;
      r.block_offset   = ofs;
      r.already_listed = listed;
      r.initial_refs   = refs;
      return r;
   endfunction

   // One beat: hold valid and payload until the DUT takes it, then log it.
   task automatic send_beat(input req_type r);
      req_data  <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(r);
      beats_sent++;
   endtask

   // Random idle after a beat. Short gaps are common; the long ones start
   // while the block is still scanning the request just sent.
   task automatic pause_sender();
      int gap;
      int roll;
      roll = $urandom_range(0, 99);
      gap  = 0;
      if (steady_run) gap = 0;
      else if (roll < 16) gap = $urandom_range(1, 4);
      else if (roll < 21) gap = $urandom_range(5, 30);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Random request. In a draining stretch removes dominate so the table
   // empties out; otherwise adds dominate so it fills and hits full.
   // Only the few heavy pool entries get huge counts, so slots keep
   // turning over instead of clogging with saturated entries.
   function automatic req_type random_request(bit draining);
      req_type r;
      int      roll;
      int      idx;
      roll = $urandom_range(0, 99);
      if (roll < (draining ? 20 : 52)) r.mode = MODE_ADD;
      else if (roll < 78) r.mode = MODE_REMOVE;
      else if (roll < 96) r.mode = MODE_LOOKUP;
      else r.mode = MODE_UNUSED;

      idx  = $urandom_range(0, POOL_SIZE - 1);
      roll = $urandom_range(0, 99);
      if (roll < 3) r.block_offset = '0;
      else if (r.mode != MODE_ADD && roll < 9) r.block_offset = $urandom();  // likely miss
      else r.block_offset = offset_pool[idx];

      r.already_listed = ($urandom_range(0, 9) == 0);

      roll = $urandom_range(0, 99);
      if (idx < HEAVY_SLOTS && roll < 30) r.initial_refs = 16'($urandom());
      else if (idx < HEAVY_SLOTS && roll < 50) r.initial_refs = 16'($urandom_range(65533, 65535));
      else if (roll < 85) r.initial_refs = 16'($urandom_range(0, 2));
      else r.initial_refs = 16'($urandom_range(3, 12));
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Response side: check every accepted beat, and stall in runs of
   // random length or single cycles, about a fifth of the time overall.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_data);
      if (steady_run) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 999) < 15) begin
         stall_left = $urandom_range(0, 23);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < 6);
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      foreach (offset_pool[i]) begin
         offset_pool[i] = $urandom();
         if (offset_pool[i] == '0) offset_pool[i] = 32'h1;
      end
      // the saturated corner entry stays behind, so random traffic owns it
      offset_pool[0] = 32'hFFFF_FFFF;

      // corner cases, in an order that walks the table through its states
      corner_reqs.push_back(make_req(MODE_REMOVE, 32'h0000_1234, 1'b0, 16'd0)); // empty table
      corner_reqs.push_back(make_req(MODE_LOOKUP, 32'h0, 1'b0, 16'd0));         // lookup of 0 misses
      corner_reqs.push_back(make_req(MODE_ADD, 32'h0, 1'b0, 16'd7));           // zero offset
      corner_reqs.push_back(make_req(MODE_REMOVE, 32'h0, 1'b0, 16'd0));        // zero offset
      corner_reqs.push_back(make_req(MODE_ADD, 32'h0000_0055, 1'b1, 16'd3));   // already listed
      corner_reqs.push_back(make_req(MODE_UNUSED, 32'hFFFF_FFFF, 1'b1, 16'hFFFF));
      corner_reqs.push_back(make_req(MODE_ADD, 32'hFFFF_FFFF, 1'b0, 16'hFFFF)); // saturating store
      corner_reqs.push_back(make_req(MODE_ADD, 32'hFFFF_FFFF, 1'b0, 16'd5));   // dup at max
      corner_reqs.push_back(make_req(MODE_LOOKUP, 32'hFFFF_FFFF, 1'b0, 16'd0)); // lookup at max
      corner_reqs.push_back(make_req(MODE_REMOVE, 32'hFFFF_FFFF, 1'b0, 16'd0)); // plain decrement
      corner_reqs.push_back(make_req(MODE_ADD, 32'h0000_0001, 1'b0, 16'd0));   // count of one
      corner_reqs.push_back(make_req(MODE_REMOVE, 32'h0000_0001, 1'b0, 16'd0)); // frees the slot
      corner_reqs.push_back(make_req(MODE_LOOKUP, 32'h0000_ABCD, 1'b0, 16'd0)); // miss
      // walking-one offsets fill the remaining fifteen slots
      for (int i = 1; i < SLOTS; i++)
         corner_reqs.push_back(make_req(MODE_ADD, 32'h1 << i, 1'b0, 16'd0));
      corner_reqs.push_back(make_req(MODE_ADD, 32'h8000_0000, 1'b0, 16'd0));   // full
      corner_reqs.push_back(make_req(MODE_ADD, 32'h0000_0002, 1'b0, 16'd0));   // dup while full
      // release the walking-one entries so random traffic finds free slots
      for (int i = 1; i < SLOTS; i++)
         corner_reqs.push_back(make_req(MODE_REMOVE, 32'h1 << i, 1'b0, 16'd0));
      corner_reqs.push_back(make_req(MODE_REMOVE, 32'h0000_0002, 1'b0, 16'd0)); // dup'd entry

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (corner_reqs[i]) begin
         send_beat(corner_reqs[i]);
         pause_sender();
      end

      // random traffic, alternating fill and drain stretches, with one
      // stretch of back-to-back beats and no response stalls
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         steady_run = (n >= 700 && n < 1000);
         send_beat(random_request((n / 200) % 2 == 1));
         pause_sender();
      end
      req_valid <= 1'b0;

      // drain, then give a stray extra response time to show up
      while (board.awaited_rsps.size() != 0) @(posedge clock);
      repeat (SLOTS + 8) @(posedge clock);

      $display("Sent %0d request beats (%0d corner cases); checked %0d responses, %0d errors",
               beats_sent, corner_reqs.size(), board.checked, board.errors);
      $display("Outcomes: ok %0d, zero %0d, listed %0d, dup %0d, full %0d, empty %0d, miss %0d, freed %0d",
               board.status_seen[STAT_OK], board.status_seen[STAT_ZERO],
               board.status_seen[STAT_LISTED], board.status_seen[STAT_DUP],
               board.status_seen[STAT_FULL], board.status_seen[STAT_EMPTY],
               board.status_seen[STAT_MISS], board.freed_seen);
      if (board.errors == 0 && board.awaited_rsps.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // hang guard, several times the slowest legal run
   initial begin
      #12_000_000;
      $display("Timeout with %0d responses outstanding", board.awaited_rsps.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
